// ===== rtl/ycds_pkg.sv =====
// Shared types and constants for the YCbCr color distance summer.
// Fixed-point widths, luma/chroma coefficients, queue item and sequencer state.
// No dependencies.
`default_nettype none

package ycds_pkg;

    localparam int FRAC_BITS = 8;          // fraction bits of luma, chroma and distance

    localparam int PIX_W  = 32;
    localparam int DIFF_W = 9;             // signed channel difference
    localparam int SUM_W  = 40;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Q0.16 coefficients
    localparam int KY_R = 19595;
    localparam int KY_G = 38470;
    localparam int KY_B = 7471;
    localparam int K_CB = 36962;
    localparam int K_CR = 46727;

    localparam int ACC_W  = 26;            // luma difference in Q16, also B*2^16 - Y
    localparam int PROD_W = 44;            // chroma coefficient product
    localparam int SH_Y   = 16 - FRAC_BITS;
    localparam int SH_C   = 32 - FRAC_BITS;
    localparam int DY_W   = FRAC_BITS + 10;
    localparam int CH_W   = FRAC_BITS + 11;
    localparam int SQ_W   = 2 * CH_W;
    localparam int RAD_W  = SQ_W + 4;      // 4*S, even width
    localparam int RT_W   = RAD_W / 2;     // root width, one bit per cycle
    localparam int RCNT_W = $clog2(RT_W);

    typedef struct packed {
        logic signed [DIFF_W-1:0] dr;
        logic signed [DIFF_W-1:0] dg;
        logic signed [DIFF_W-1:0] db;
        logic                     sel;     // pixel takes part in the sum
        logic                     last;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LUMA,
        ST_CHROMA,
        ST_ROUND,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_ACCUM
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/ycds_ifs.sv =====
// Valid/ready channels of the color distance summer: pixel pairs in, frame sums out.
// Depends on ycds_pkg for field widths.
`default_nettype none

interface ycds_pix_if;
    logic                        valid;
    logic                        ready;
    logic [ycds_pkg::PIX_W-1:0]  pixel_a;
    logic [ycds_pkg::PIX_W-1:0]  pixel_b;
    logic                        last_pixel;

    modport source (output valid, pixel_a, pixel_b, last_pixel, input ready);
    modport sink   (input valid, pixel_a, pixel_b, last_pixel, output ready);
endinterface

interface ycds_sum_if;
    logic                        valid;
    logic                        ready;
    logic [ycds_pkg::SUM_W-1:0]  frame_sum;

    modport source (output valid, frame_sum, input ready);
    modport sink   (input valid, frame_sum, output ready);
endinterface

`default_nettype wire

// ===== rtl/ycds_fifo.sv =====
// Short item queue between the front and back of the color distance summer.
// Depends on ycds_pkg (t_item). DEPTH must be 2 or more.
`default_nettype none

module ycds_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ycds_pkg::t_item i_data,
    output logic            o_full,
    input  logic            i_pop,
    output ycds_pkg::t_item o_data,
    output logic            o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    ycds_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ycds_front.sv =====
// Front end: takes pixel pairs, forms channel differences and marks which
// pixels count under the stride mode. Holds the mode register and pixel parity.
// Depends on ycds_pkg and ycds_ifs.
`default_nettype none

module ycds_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    ycds_pix_if.sink        i_pix,
    input  logic            i_full,
    output logic            o_push,
    output ycds_pkg::t_item o_item
);

    logic r_stride;
    logic r_parity;

    assign i_pix.ready = !i_full;
    assign o_push      = i_pix.valid && !i_full;

    always_comb begin
        o_item.dr   = $signed({1'b0, i_pix.pixel_a[7:0]})   - $signed({1'b0, i_pix.pixel_b[7:0]});
        o_item.dg   = $signed({1'b0, i_pix.pixel_a[15:8]})  - $signed({1'b0, i_pix.pixel_b[15:8]});
        o_item.db   = $signed({1'b0, i_pix.pixel_a[23:16]}) - $signed({1'b0, i_pix.pixel_b[23:16]});
        o_item.sel  = !r_stride || !r_parity;
        o_item.last = i_pix.last_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= 1'b1;
            r_parity <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_stride <= i_cfg_wdata;
            end
            if (o_push) begin
                // parity restarts at even with each frame
                r_parity <= i_pix.last_pixel ? 1'b0 : !r_parity;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ycds_back.sv =====
// Back end: per-pixel YCbCr distance through a multi-cycle sequencer with a
// bit-serial square root, saturating frame accumulation and output register.
// Depends on ycds_pkg and ycds_ifs.
`default_nettype none

module ycds_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  ycds_pkg::t_item i_item,
    output logic            o_pop,
    ycds_sum_if.source      o_sum
);

    localparam int ACC_W  = ycds_pkg::ACC_W;
    localparam int PROD_W = ycds_pkg::PROD_W;
    localparam int DY_W   = ycds_pkg::DY_W;
    localparam int CH_W   = ycds_pkg::CH_W;
    localparam int SQ_W   = ycds_pkg::SQ_W;
    localparam int RAD_W  = ycds_pkg::RAD_W;
    localparam int RT_W   = ycds_pkg::RT_W;
    localparam int RCNT_W = ycds_pkg::RCNT_W;
    localparam int SUM_W  = ycds_pkg::SUM_W;
    localparam int SH_Y   = ycds_pkg::SH_Y;
    localparam int SH_C   = ycds_pkg::SH_C;

    localparam logic signed [ACC_W-1:0]  C_YR = ACC_W'(ycds_pkg::KY_R);
    localparam logic signed [ACC_W-1:0]  C_YG = ACC_W'(ycds_pkg::KY_G);
    localparam logic signed [ACC_W-1:0]  C_YB = ACC_W'(ycds_pkg::KY_B);
    localparam logic signed [PROD_W-1:0] C_CB = PROD_W'(ycds_pkg::K_CB);
    localparam logic signed [PROD_W-1:0] C_CR = PROD_W'(ycds_pkg::K_CR);

    // round to nearest, ties away from zero: (v + half - neg) >>> sh
    localparam bit                      ADJ_Y  = (SH_Y > 0);
    localparam logic signed [ACC_W-1:0]  HALF_Y = ADJ_Y ? (ACC_W'(1) << (SH_Y - 1)) : ACC_W'(0);
    localparam logic signed [PROD_W-1:0] HALF_C = PROD_W'(1) << (SH_C - 1);

    ycds_pkg::t_state r_state;
    ycds_pkg::t_state n_state;

    ycds_pkg::t_item           r_item;
    logic signed [ACC_W-1:0]   r_dy_acc;
    logic signed [DY_W-1:0]    r_dy;
    logic signed [PROD_W-1:0]  r_pcb;
    logic signed [PROD_W-1:0]  r_pcr;
    logic signed [CH_W-1:0]    r_dcb;
    logic signed [CH_W-1:0]    r_dcr;
    logic [SQ_W-1:0]           r_sq_y;
    logic [SQ_W-1:0]           r_sq_cb;
    logic [SQ_W-1:0]           r_sq_cr;
    logic [RAD_W-1:0]          r_rad;
    logic [RT_W:0]             r_rem;
    logic [RT_W-1:0]           r_root;
    logic [RCNT_W-1:0]         r_cnt;
    logic [SUM_W-1:0]          r_sum;
    logic [SUM_W-1:0]          r_frame_sum;
    logic                      r_out_valid;

    logic signed [ACC_W-1:0]   dy_acc_n;
    logic signed [ACC_W-1:0]   cb_arg;
    logic signed [ACC_W-1:0]   cr_arg;
    logic signed [PROD_W-1:0]  pcb_n;
    logic signed [PROD_W-1:0]  pcr_n;
    logic signed [ACC_W-1:0]   dy_tmp;
    logic signed [PROD_W-1:0]  cb_tmp;
    logic signed [PROD_W-1:0]  cr_tmp;
    logic signed [SQ_W-1:0]    sq_y_s;
    logic signed [SQ_W-1:0]    sq_cb_s;
    logic signed [SQ_W-1:0]    sq_cr_s;
    logic [RAD_W-1:0]          rad_n;
    logic [RT_W+1:0]           rem_sh;
    logic [RT_W+1:0]           trial;
    logic                      take;
    logic [RT_W:0]             dist_p;
    logic [SUM_W:0]            acc;
    logic [SUM_W-1:0]          sum_sat;
    logic                      out_free;
    logic                      accum_done;

    always_comb begin
        dy_acc_n = C_YR * r_item.dr + C_YG * r_item.dg + C_YB * r_item.db;

        cb_arg = (ACC_W'(r_item.db) <<< 16) - r_dy_acc;
        cr_arg = (ACC_W'(r_item.dr) <<< 16) - r_dy_acc;
        pcb_n  = C_CB * cb_arg;
        pcr_n  = C_CR * cr_arg;

        dy_tmp = r_dy_acc + HALF_Y - ACC_W'(ADJ_Y & r_dy_acc[ACC_W-1]);
        cb_tmp = r_pcb + HALF_C - PROD_W'(r_pcb[PROD_W-1]);
        cr_tmp = r_pcr + HALF_C - PROD_W'(r_pcr[PROD_W-1]);

        sq_y_s  = r_dy * r_dy;
        sq_cb_s = r_dcb * r_dcb;
        sq_cr_s = r_dcr * r_dcr;

        // 4*S = 4*dy^2 + 2*dcb^2 + 2*dcr^2
        rad_n = (RAD_W'(r_sq_y) << 2) + (RAD_W'(r_sq_cb) << 1) + (RAD_W'(r_sq_cr) << 1);

        // one root bit per cycle, two radicand bits brought down
        rem_sh = {r_rem[RT_W-1:0], r_rad[RAD_W-1 -: 2]};
        trial  = {r_root, 2'b01};
        take   = (rem_sh >= trial);

        dist_p  = (RT_W + 1)'(r_root) + (RT_W + 1)'(1);
        acc     = {1'b0, r_sum} + (r_item.sel ? (SUM_W + 1)'(dist_p[RT_W:1]) : '0);
        sum_sat = acc[SUM_W] ? ycds_pkg::SUM_MAX : acc[SUM_W-1:0];
    end

    assign out_free    = !r_out_valid || o_sum.ready;
    assign o_sum.valid     = r_out_valid;
    assign o_sum.frame_sum = r_frame_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ycds_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        accum_done = 1'b0;
        case (r_state)
            ycds_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = i_item.sel ? ycds_pkg::ST_LUMA : ycds_pkg::ST_ACCUM;
                end
            end
            ycds_pkg::ST_LUMA:   n_state = ycds_pkg::ST_CHROMA;
            ycds_pkg::ST_CHROMA: n_state = ycds_pkg::ST_ROUND;
            ycds_pkg::ST_ROUND:  n_state = ycds_pkg::ST_SQUARE;
            ycds_pkg::ST_SQUARE: n_state = ycds_pkg::ST_SUM;
            ycds_pkg::ST_SUM:    n_state = ycds_pkg::ST_ROOT;
            ycds_pkg::ST_ROOT: begin
                if (r_cnt == '0) begin
                    n_state = ycds_pkg::ST_ACCUM;
                end
            end
            ycds_pkg::ST_ACCUM: begin
                // a frame end waits for the output register
                if (!r_item.last || out_free) begin
                    accum_done = 1'b1;
                    n_state    = ycds_pkg::ST_IDLE;
                end
            end
            default: n_state = ycds_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ycds_pkg::ST_IDLE: begin
                r_item <= i_item;
            end
            ycds_pkg::ST_LUMA: begin
                r_dy_acc <= dy_acc_n;
            end
            ycds_pkg::ST_CHROMA: begin
                r_pcb <= pcb_n;
                r_pcr <= pcr_n;
                r_dy  <= DY_W'(dy_tmp >>> SH_Y);
            end
            ycds_pkg::ST_ROUND: begin
                r_dcb <= CH_W'(cb_tmp >>> SH_C);
                r_dcr <= CH_W'(cr_tmp >>> SH_C);
            end
            ycds_pkg::ST_SQUARE: begin
                r_sq_y  <= $unsigned(sq_y_s);
                r_sq_cb <= $unsigned(sq_cb_s);
                r_sq_cr <= $unsigned(sq_cr_s);
            end
            ycds_pkg::ST_SUM: begin
                r_rad  <= rad_n;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= RCNT_W'(RT_W - 1);
            end
            ycds_pkg::ST_ROOT: begin
                r_rad  <= r_rad << 2;
                r_rem  <= take ? (RT_W + 1)'(rem_sh - trial) : rem_sh[RT_W:0];
                r_root <= {r_root[RT_W-2:0], take};
                r_cnt  <= r_cnt - RCNT_W'(1);
            end
            default: begin
                r_item <= r_item;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accum_done && r_item.last) begin
            r_frame_sum <= sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accum_done) begin
                r_sum <= r_item.last ? '0 : sum_sat;
            end
            if (accum_done && r_item.last) begin
                r_out_valid <= 1'b1;
            end else if (o_sum.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ycbcr_color_distance_sum.sv =====
// Top level of the YCbCr color distance summer: front end, item queue, back end.
// Depends on ycds_pkg, ycds_ifs, ycds_front, ycds_fifo and ycds_back.
//
// Takes one pixel pair per beat on i_pix and returns the saturating frame sum of
// sqrt(dY^2 + (dCb^2 + dCr^2)/2), 8 fraction bits, on o_sum after the beat
// marked last_pixel. The front end accepts a pair every cycle while the queue
// (QUEUE_DEPTH entries) has room. The back end steps each counted pair through
// the states LUMA, CHROMA, ROUND, SQUARE, SUM, ROOT and ACCUM, with the square
// root yielding one bit per cycle; a pair skipped by stride mode only does ACCUM.
// The back end takes no new pair before it is through with the last one. The frame
// sum waits in an output register, so processing of the next frame continues
// while it is pending. stride_mode (reset 1) is written through i_cfg_we /
// i_cfg_wdata; the user must do this only while the block is idle (not enforced).
`default_nettype none

module ycbcr_color_distance_sum #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    ycds_pix_if.sink    i_pix,
    ycds_sum_if.source  o_sum
);

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    ycds_pkg::t_item push_item;
    ycds_pkg::t_item pop_item;

    ycds_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (i_pix),
        .i_full      (full),
        .o_push      (push),
        .o_item      (push_item)
    );

    ycds_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_item),
        .o_empty (empty)
    );

    ycds_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_item  (pop_item),
        .o_pop   (pop),
        .o_sum   (o_sum)
    );

endmodule

`default_nettype wire
